### design/rbf_kernel_evaluator_top_macros.svh
// Assertion macros for the RBF kernel evaluator checker.
// Depends on a clock named clock and a reset named reset in the using scope.
`ifndef RBF_KERNEL_EVALUATOR_TOP_MACROS_SVH
`define RBF_KERNEL_EVALUATOR_TOP_MACROS_SVH

// Check that cond holds in the cycle after trig, reset or not.
`define RBFK_ASSERT_NEXT(label, trig, cond) \
   label: assert property (@(posedge clock) (trig) |=> (cond)) \
      else $error("rbf kernel evaluator: check failed");

// Check that cond holds in the cycle after trig, outside reset.
`define RBFK_ASSERT_NEXT_RUN(label, trig, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error("rbf kernel evaluator: check failed");

// Check that cond holds at every edge outside reset.
`define RBFK_ASSERT_ALWAYS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("rbf kernel evaluator: check failed");

`endif

### design/rbfk_pkg.sv
// Shared types, constants and table builder for the RBF kernel evaluator.
// No dependencies.
`default_nettype none

package rbfk_pkg;

   localparam int COORD_W   = 16;
   localparam int ACC_W     = 40;
   localparam int SQ_W      = 32;
   localparam int VAR_W     = 16;
   localparam int SCALE_W   = 24;
   localparam int KERNEL_W  = 24;
   localparam int ENTRY_W   = 17;

   localparam int MID_DEPTH = 4;
   localparam int MID_CNT_W = 3;
   localparam int OUT_DEPTH = 4;
   localparam int OUT_CNT_W = 3;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 24;

   localparam logic [CSR_INDEX_W-1:0] CSR_VARIANCE_GAIN  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DISTANCE_SCALE = 2'd1;

   localparam logic [VAR_W-1:0]   VARIANCE_GAIN_RESET  = 16'd256;
   localparam logic [SCALE_W-1:0] DISTANCE_SCALE_RESET = 24'd23637;

   typedef struct packed {
      logic [ACC_W-1:0] distance;
      logic             sat;
   } mid_item_type;

   typedef struct packed {
      logic [KERNEL_W-1:0] kernel;
      logic                sat;
   } rsp_item_type;

   typedef struct packed {
      logic [VAR_W-1:0]   variance_gain;
      logic [SCALE_W-1:0] distance_scale;
   } cfg_type;

   // Integer square root, bit by bit.
   function automatic logic [63:0] isqrt64(logic [63:0] n);
      logic [63:0] rem_v;
      logic [63:0] res_v;
      logic [63:0] bit_v;
      rem_v = n;
      res_v = '0;
      bit_v = 64'h4000_0000_0000_0000;
      for (int k = 0; k < 32; k++) begin
         if (bit_v > rem_v) bit_v = bit_v >> 2;
      end
      for (int k = 0; k < 32; k++) begin
         if (bit_v != 64'd0) begin
            if (rem_v >= res_v + bit_v) begin
               rem_v = rem_v - (res_v + bit_v);
               res_v = (res_v >> 1) + bit_v;
            end else begin
               res_v = res_v >> 1;
            end
            bit_v = bit_v >> 2;
         end
      end
      return res_v;
   endfunction

   // Table entry round(65536 * 2^(-idx/2^bits)), built from Q0.32 roots of one half.
   function automatic logic [ENTRY_W-1:0] pow2_entry(int unsigned idx, int unsigned bits);
      logic [63:0] roots [17];
      logic [63:0] p;
      logic [63:0] q;
      roots[0] = 64'd1 << 31;
      for (int k = 1; k <= 16; k++) begin
         roots[k] = isqrt64(roots[k-1] << 32);
      end
      p = 64'd1 << 32;
      for (int unsigned m = 0; m < bits; m++) begin
         if (((idx >> m) & 1) != 0) p = (p * roots[bits - m] + (64'd1 << 31)) >> 32;
      end
      q = (p + 64'd32768) >> 16;
      return q[ENTRY_W-1:0];
   endfunction

endpackage

`default_nettype wire

### design/rbfk_queue.sv
// Small first-in first-out queue with an occupancy count.
// Depends on nothing; the caller guards against overfill.
`default_nettype none

module rbfk_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           push,
   input  wire logic [WIDTH-1:0]               wdata,
   input  wire logic                           pop,
   output logic      [WIDTH-1:0]               rdata,
   output logic                                empty,
   output logic      [$clog2(DEPTH+1)-1:0]     count
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH+1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign do_pop  = pop && (count_ff != '0);
   assign do_push = push;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (!do_push && do_pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= wdata;
   end

   assign rdata = slot_ff[rd_ptr_ff];
   assign empty = (count_ff == '0);
   assign count = count_ff;

endmodule

`default_nettype wire

### design/rbfk_front.sv
// Front end: takes coordinate pairs, squares their difference and accumulates.
// Depends on rbfk_pkg; hands finished distances to the middle queue.
`default_nettype none

module rbfk_front (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                push,
   input  wire logic signed [rbfk_pkg::COORD_W-1:0] coord_first,
   input  wire logic signed [rbfk_pkg::COORD_W-1:0] coord_second,
   input  wire logic                                last_coord,
   input  wire logic [rbfk_pkg::MID_CNT_W-1:0]      mid_count,
   output logic                                     full,
   output logic                                     mid_push,
   output rbfk_pkg::mid_item_type                   mid_item
);

   import rbfk_pkg::*;

   logic                      accept;
   logic                      s1_valid_ff;
   logic                      s1_last_ff;
   logic signed [COORD_W:0]   diff_ff;
   logic                      s2_valid_ff;
   logic                      s2_last_ff;
   logic [SQ_W-1:0]           sq_ff;
   logic signed [2*COORD_W+1:0] sq_full;
   logic [ACC_W-1:0]          acc_ff, acc_in;
   logic                      flag_ff, flag_in;
   logic [ACC_W:0]            sum;
   logic [ACC_W-1:0]          acc_sat;
   logic                      flag_now;
   logic [MID_CNT_W-1:0]      reserved;

   // Reserve a queue slot for every last item still in the pipe.
   assign reserved = mid_count + {{(MID_CNT_W-1){1'b0}}, s1_valid_ff & s1_last_ff}
                               + {{(MID_CNT_W-1){1'b0}}, s2_valid_ff & s2_last_ff};
   assign full     = (reserved >= MID_CNT_W'(MID_DEPTH));
   assign accept   = push && !full;

   assign sq_full  = diff_ff * diff_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_last_ff <= last_coord;
      diff_ff    <= {coord_first[COORD_W-1], coord_first}
                    - {coord_second[COORD_W-1], coord_second};
      s2_last_ff <= s1_last_ff;
      sq_ff      <= sq_full[SQ_W-1:0];
   end

   // Saturating add of the square, then clear on the last coordinate.
   always_comb begin
      sum      = {1'b0, acc_ff} + {{(ACC_W+1-SQ_W){1'b0}}, sq_ff};
      acc_sat  = sum[ACC_W] ? {ACC_W{1'b1}} : sum[ACC_W-1:0];
      flag_now = flag_ff | sum[ACC_W];
      acc_in   = acc_ff;
      flag_in  = flag_ff;
      if (s2_valid_ff) begin
         if (s2_last_ff) begin
            acc_in  = '0;
            flag_in = 1'b0;
         end else begin
            acc_in  = acc_sat;
            flag_in = flag_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         flag_ff <= 1'b0;
      end else begin
         acc_ff  <= acc_in;
         flag_ff <= flag_in;
      end
   end

   assign mid_push          = s2_valid_ff && s2_last_ff;
   assign mid_item.distance = acc_sat;
   assign mid_item.sat      = flag_now;

endmodule

`default_nettype wire

### design/rbfk_back.sv
// Back end: scales the distance, looks up the power of two and applies variance.
// Depends on rbfk_pkg; drains the middle queue into the result queue.
`default_nettype none

module rbfk_back #(
   parameter int EXP_TABLE_SIZE = 256
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  rbfk_pkg::cfg_type                  cfg,
   input  wire logic                          mid_empty,
   input  rbfk_pkg::mid_item_type             mid_item,
   output logic                               mid_pop,
   input  wire logic [rbfk_pkg::OUT_CNT_W-1:0] out_count,
   output logic                               out_push,
   output rbfk_pkg::rsp_item_type             out_item
);

   import rbfk_pkg::*;

   localparam int TBL_BITS = $clog2(EXP_TABLE_SIZE + 1) - 1;
   localparam int TBL_N    = 1 << TBL_BITS;
   localparam int HALF_W   = ACC_W / 2;
   localparam int PP_W     = HALF_W + SCALE_W;

   function automatic logic [TBL_N*ENTRY_W-1:0] build_flat();
      logic [TBL_N*ENTRY_W-1:0] flat;
      flat = '0;
      for (int i = 0; i < TBL_N; i++) begin
         flat[i*ENTRY_W +: ENTRY_W] = pow2_entry(i, TBL_BITS);
      end
      return flat;
   endfunction

   localparam logic [TBL_N*ENTRY_W-1:0] POW2_FLAT = build_flat();

   logic                 b1_valid_ff, b2_valid_ff, b3_valid_ff;
   logic [PP_W-1:0]      pp_lo_ff, pp_hi_ff;
   logic                 b1_sat_ff, b2_sat_ff, b3_sat_ff;
   logic [63:0]          expo;
   logic [TBL_BITS-1:0]  idx;
   logic [ENTRY_W-1:0]   entry_ff;
   logic [3:0]           ip_ff;
   logic                 big_ff;
   logic [ENTRY_W-1:0]   shifted;
   logic [VAR_W+ENTRY_W-1:0] prod;
   logic [KERNEL_W-1:0]  kernel_ff;
   logic [OUT_CNT_W-1:0] pending;

   // Pop only when the result queue has room for everything in flight.
   assign pending = out_count + {{(OUT_CNT_W-1){1'b0}}, b1_valid_ff}
                              + {{(OUT_CNT_W-1){1'b0}}, b2_valid_ff}
                              + {{(OUT_CNT_W-1){1'b0}}, b3_valid_ff};
   assign mid_pop = !mid_empty && (pending < OUT_CNT_W'(OUT_DEPTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
         b2_valid_ff <= 1'b0;
         b3_valid_ff <= 1'b0;
      end else begin
         b1_valid_ff <= mid_pop;
         b2_valid_ff <= b1_valid_ff;
         b3_valid_ff <= b2_valid_ff;
      end
   end

   // Split the 40 by 24 product into two halves.
   always_ff @(posedge clock) begin
      pp_lo_ff  <= PP_W'(mid_item.distance[HALF_W-1:0]) * PP_W'(cfg.distance_scale);
      pp_hi_ff  <= PP_W'(mid_item.distance[ACC_W-1:HALF_W]) * PP_W'(cfg.distance_scale);
      b1_sat_ff <= mid_item.sat;
   end

   assign expo = {pp_hi_ff, {HALF_W{1'b0}}} + {{(64-PP_W){1'b0}}, pp_lo_ff};
   assign idx  = expo[31 -: TBL_BITS];

   always_ff @(posedge clock) begin
      entry_ff  <= POW2_FLAT[idx*ENTRY_W +: ENTRY_W];
      ip_ff     <= expo[35:32];
      big_ff    <= |expo[63:36];
      b2_sat_ff <= b1_sat_ff;
   end

   assign shifted = big_ff ? '0 : (entry_ff >> ip_ff);
   assign prod    = {{ENTRY_W{1'b0}}, cfg.variance_gain} * {{VAR_W{1'b0}}, shifted};

   always_ff @(posedge clock) begin
      kernel_ff <= prod[KERNEL_W+7:8];
      b3_sat_ff <= b2_sat_ff;
   end

   assign out_item.kernel = kernel_ff;
   assign out_item.sat    = b3_sat_ff;
   assign out_push        = b3_valid_ff;

endmodule

`default_nettype wire

### design/rbf_kernel_evaluator_top.sv
// A last coordinate passes s1, s2, the middle queue, b1, b2, b3 and the result queue to rsp_.
// Throughput: one coordinate pair a cycle into the front while req_full is low; finished
// vectors cannot leave the back end every cycle, as its room check counts the result
// being popped, not even in a run of one-coordinate vectors.
// req_full rises while four finished distances are queued or reserved for the back end.
// Reset: synchronous, active high; clears pipes, queues, accumulator; presets registers.
`default_nettype none

module rbf_kernel_evaluator_top #(
   parameter int EXP_TABLE_SIZE = 256
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // coordinate pairs in
   input  wire logic                                  req_push,
   output logic                                       req_full,
   input  wire logic signed [rbfk_pkg::COORD_W-1:0]   req_coord_first,
   input  wire logic signed [rbfk_pkg::COORD_W-1:0]   req_coord_second,
   input  wire logic                                  req_last_coord,
   // kernel values out
   output logic                                       rsp_empty,
   input  wire logic                                  rsp_pop,
   output logic [rbfk_pkg::KERNEL_W-1:0]              rsp_kernel_value,
   output logic                                       rsp_distance_saturated,
   // register writes
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [rbfk_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [rbfk_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   import rbfk_pkg::*;

   localparam int MID_W = $bits(mid_item_type);
   localparam int RSP_W = $bits(rsp_item_type);

   cfg_type              cfg_ff, cfg_in;
   logic                 mid_push;
   logic                 mid_pop;
   logic                 mid_empty;
   logic [MID_CNT_W-1:0] mid_count;
   mid_item_type         mid_wr_item;
   mid_item_type         mid_rd_item;
   logic [MID_W-1:0]     mid_rd_bits;
   logic                 out_push;
   logic [OUT_CNT_W-1:0] out_count;
   rsp_item_type         out_wr_item;
   rsp_item_type         out_rd_item;
   logic [RSP_W-1:0]     out_rd_bits;

   // Registers are always writable; writes to unused indexes drop.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_VARIANCE_GAIN:  cfg_in.variance_gain  = csr_wdata[VAR_W-1:0];
            CSR_DISTANCE_SCALE: cfg_in.distance_scale = csr_wdata[SCALE_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.variance_gain  <= VARIANCE_GAIN_RESET;
         cfg_ff.distance_scale <= DISTANCE_SCALE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: difference, square, saturating accumulate.
   rbfk_front u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (req_push),
      .coord_first  (req_coord_first),
      .coord_second (req_coord_second),
      .last_coord   (req_last_coord),
      .mid_count    (mid_count),
      .full         (req_full),
      .mid_push     (mid_push),
      .mid_item     (mid_wr_item)
   );

   // Hold finished distances until the back end is free.
   rbfk_queue #(
      .WIDTH (MID_W),
      .DEPTH (MID_DEPTH)
   ) u_mid_queue (
      .clock (clock),
      .reset (reset),
      .push  (mid_push),
      .wdata (mid_wr_item),
      .pop   (mid_pop),
      .rdata (mid_rd_bits),
      .empty (mid_empty),
      .count (mid_count)
   );

   assign mid_rd_item = mid_rd_bits;

   // Back: scale, exponential table, variance.
   rbfk_back #(
      .EXP_TABLE_SIZE (EXP_TABLE_SIZE)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .mid_empty (mid_empty),
      .mid_item  (mid_rd_item),
      .mid_pop   (mid_pop),
      .out_count (out_count),
      .out_push  (out_push),
      .out_item  (out_wr_item)
   );

   // Result queue parts the back end from the consumer.
   rbfk_queue #(
      .WIDTH (RSP_W),
      .DEPTH (OUT_DEPTH)
   ) u_out_queue (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .wdata (out_wr_item),
      .pop   (rsp_pop),
      .rdata (out_rd_bits),
      .empty (rsp_empty),
      .count (out_count)
   );

   assign out_rd_item            = out_rd_bits;
   assign rsp_kernel_value       = out_rd_item.kernel;
   assign rsp_distance_saturated = out_rd_item.sat;

endmodule

`default_nettype wire

### design/rbfk_checker.sv
// Port-level checks for the RBF kernel evaluator, bound to its top level.
// Depends on rbfk_pkg and rbf_kernel_evaluator_top_macros.svh.
`default_nettype none

`include "rbf_kernel_evaluator_top_macros.svh"

module rbfk_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_full,
   input wire logic                                rsp_empty,
   input wire logic                                rsp_pop,
   input wire logic [rbfk_pkg::KERNEL_W-1:0]       rsp_kernel_value,
   input wire logic                                rsp_distance_saturated,
   input wire logic                                csr_ready
);

   // Reset leaves no result waiting and the input open.
   `RBFK_ASSERT_NEXT(a_reset_state, reset, rsp_empty && !req_full)

   // A waiting result that is not taken stays put.
   `RBFK_ASSERT_NEXT_RUN(a_rsp_keep, !rsp_empty && !rsp_pop, !rsp_empty)
   `RBFK_ASSERT_NEXT_RUN(a_rsp_value, !rsp_empty && !rsp_pop, $stable(rsp_kernel_value))
   `RBFK_ASSERT_NEXT_RUN(a_rsp_flag, !rsp_empty && !rsp_pop, $stable(rsp_distance_saturated))

   // Register writes never stall.
   `RBFK_ASSERT_ALWAYS(a_csr_ready, csr_ready)

endmodule

bind rbf_kernel_evaluator_top rbfk_checker u_rbfk_checker (.*);

`default_nettype wire

### sim/tb_rbf_kernel_evaluator_top.sv
// Self-checking bench for rbf_kernel_evaluator_top: streams coordinate pairs,
// predicts each kernel value in-bench and compares the rsp_ items field by field.
// Depends on rbfk_pkg and the evaluator RTL.
`timescale 1ns / 1ps

module tb_rbf_kernel_evaluator_top;

   import rbfk_pkg::*;

   // Exponential table depth used by the block; only 2^LUT_BITS entries are live.
   localparam int TABLE_SIZE   = 256;
   localparam int LUT_BITS     = $clog2(TABLE_SIZE + 1) - 1;
   localparam int LUT_DEPTH    = 1 << LUT_BITS;
   localparam int PHASES       = 6;
   localparam int RANDOM_PAIRS = 75;
   localparam int DRAIN_CYCLES = 12;
   localparam int STALL_CYCLES = 400;

   localparam logic [ACC_W-1:0] ACC_LIMIT = '1;

   // Register indexes that the block must ignore.
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_B = 2'd3;

   // Coordinate styles for generated vectors.
   typedef enum int {
      STYLE_NEAR,
      STYLE_SPREAD,
      STYLE_CORNER,
      STYLE_FLOOD
   } coord_style_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] first;
      logic signed [COORD_W-1:0] second;
      logic                      last;
   } coord_pair_type;

   localparam logic [COORD_W-1:0] CORNERS [5] = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF,
                                                   16'h0001};

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_push         = 1'b0;
   logic                      req_full;
   logic signed [COORD_W-1:0] req_coord_first  = '0;
   logic signed [COORD_W-1:0] req_coord_second = '0;
   logic                      req_last_coord   = 1'b0;

   logic                      rsp_empty;
   logic                      rsp_pop = 1'b0;
   logic [KERNEL_W-1:0]       rsp_kernel_value;
   logic                      rsp_distance_saturated;

   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]     csr_wdata = '0;

   // Pairs waiting to be offered, and kernel values owed by the block.
   coord_pair_type pending_pairs [$];
   rsp_item_type   kernel_values_due [$];

   // Mirror of the block: distance sum, saturation flag, registers and power-of-two table.
   logic [ACC_W-1:0]    dist_acc  = '0;
   logic                dist_sat  = 1'b0;
   logic [VAR_W-1:0]    cfg_gain  = VARIANCE_GAIN_RESET;
   logic [SCALE_W-1:0]  cfg_scale = DISTANCE_SCALE_RESET;
   logic [ENTRY_W-1:0]  pow2_lut [LUT_DEPTH];

   int   pairs_issued   = 0;
   int   pairs_accepted = 0;
   int   error_count    = 0;
   int   send_idle_pct  = 0;
   int   rcv_idle_pct   = 0;
   logic req_taken      = 1'b0;
   logic long_stall_req = 1'b0;

   rbf_kernel_evaluator_top #(
      .EXP_TABLE_SIZE(TABLE_SIZE)
   ) uut (
      .clock                  (clock),
      .reset                  (reset),
      .req_push               (req_push),
      .req_full               (req_full),
      .req_coord_first        (req_coord_first),
      .req_coord_second       (req_coord_second),
      .req_last_coord         (req_last_coord),
      .rsp_empty              (rsp_empty),
      .rsp_pop                (rsp_pop),
      .rsp_kernel_value       (rsp_kernel_value),
      .rsp_distance_saturated (rsp_distance_saturated),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata)
   );

   always #1 clock = ~clock;

   // Bound the run; a lost result or a stuck handshake ends here.
   initial begin
      #2_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // Sender: hold an offered pair until it is taken, then either load the next one
   // or leave req_push low. All input changes land on the falling edge.
   always @(negedge clock) begin
      coord_pair_type pair;
      if (!req_push || req_taken) begin
         if (!reset && pending_pairs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            pair = pending_pairs.pop_front();
            req_coord_first  <= pair.first;
            req_coord_second <= pair.second;
            req_last_coord   <= pair.last;
            req_push         <= 1'b1;
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // Receiver: random pops, plus one long hold-off counted here so the block
   // backs up and raises req_full while the sender keeps pushing.
   always @(negedge clock) begin
      static int   stall_left = 0;
      static logic stall_used = 1'b0;
      logic        pop_next;
      if (long_stall_req && !stall_used) begin
         stall_left = STALL_CYCLES;
         stall_used = 1'b1;
      end
      if (stall_left != 0) begin
         stall_left--;
         pop_next = 1'b0;
      end else begin
         pop_next = ($urandom_range(99) >= rcv_idle_pct);
      end
      rsp_pop <= pop_next;
   end

   // Monitor: on each accepted pair advance the distance mirror and, on the last
   // coordinate, work out the kernel value; check every popped result in order.
   always @(posedge clock) begin
      longint       diff;
      logic [40:0]  acc_sum;
      logic [63:0]  expo;
      logic [ENTRY_W-1:0] entry;
      rsp_item_type due;
      if (reset) begin
         req_taken = 1'b0;
      end else begin
         req_taken = req_push && !req_full;
         if (req_taken) begin
            diff    = longint'(req_coord_first) - longint'(req_coord_second);
            acc_sum = {1'b0, dist_acc} + 41'(diff * diff);
            // Clamp at full scale and remember it until the vector ends.
            if (acc_sum > {1'b0, ACC_LIMIT}) begin
               dist_acc = ACC_LIMIT;
               dist_sat = 1'b1;
            end else begin
               dist_acc = acc_sum[ACC_W-1:0];
            end
            pairs_accepted++;
            if (req_last_coord) begin
               // Exponent in Q.32: integer part shifts the table entry, top
               // fraction bits pick it; sixteen or more whole octaves give zero.
               expo = 64'(dist_acc) * 64'(cfg_scale);
               if (expo[63:32] >= 16) begin
                  entry = '0;
               end else begin
                  entry = pow2_lut[expo[31 -: LUT_BITS]] >> expo[63:32];
               end
               due.kernel = KERNEL_W'((33'(cfg_gain) * 33'(entry)) >> 8);
               due.sat    = dist_sat;
               kernel_values_due.push_back(due);
               dist_acc = '0;
               dist_sat = 1'b0;
            end
         end
         if (rsp_pop && !rsp_empty) begin
            if (kernel_values_due.size() == 0) begin
               $error("kernel_value %0d popped with no item due", rsp_kernel_value);
               error_count++;
            end else begin
               due = kernel_values_due.pop_front();
               if (rsp_kernel_value !== due.kernel) begin
                  $error("kernel_value: expected %0d, got %0d", due.kernel, rsp_kernel_value);
                  error_count++;
               end
               if (rsp_distance_saturated !== due.sat) begin
                  $error("distance_saturated: expected %0d, got %0d", due.sat,
                         rsp_distance_saturated);
                  error_count++;
               end
            end
         end
      end
   end

   function automatic void add_pair(input logic [COORD_W-1:0] first,
                                    input logic [COORD_W-1:0] second, input logic last);
      coord_pair_type pair;
      pair.first  = first;
      pair.second = second;
      pair.last   = last;
      pending_pairs.push_back(pair);
      pairs_issued++;
   endfunction

   // Queue one vector pair of the given length; only its final coordinate is marked last.
   function automatic void queue_vector(input int len, input coord_style_type style);
      logic [COORD_W-1:0] a;
      logic [COORD_W-1:0] b;
      int                 span;
      for (int k = 0; k < len; k++) begin
         case (style)
            STYLE_NEAR: begin
               span = 1 << $urandom_range(0, 12);
               a    = COORD_W'($urandom);
               b    = a + COORD_W'($urandom_range(0, 2 * span)) - COORD_W'(span);
            end
            STYLE_SPREAD: begin
               a = COORD_W'($urandom);
               b = COORD_W'($urandom);
            end
            STYLE_CORNER: begin
               a = CORNERS[$urandom_range(0, 4)];
               b = CORNERS[$urandom_range(0, 4)];
            end
            default: begin
               // Largest possible square every time, either sign.
               a = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
               b = ~a;
            end
         endcase
         add_pair(a, b, k == len - 1);
      end
   endfunction

   // Hold until every pair has been taken and every kernel value has come back,
   // then let the pipe settle behind any trailing unmarked coordinates.
   task automatic wait_drained();
      while (pairs_issued != pairs_accepted || kernel_values_due.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Write one register over the csr_ channel and mirror it at the handshake edge.
   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0]  data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_VARIANCE_GAIN:  cfg_gain  = data[VAR_W-1:0];
         CSR_DISTANCE_SCALE: cfg_scale = data;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [63:0]        roots [17];
      logic [63:0]        rad;
      logic [63:0]        root;
      logic [63:0]        probe;
      logic [63:0]        prod;
      logic [VAR_W-1:0]   gain;
      logic [SCALE_W-1:0] scale;
      int                 mark;
      int                 pick;
      int                 len;
      coord_style_type    style;

      // Build the 2^(-i/2^L) table: successive square roots of one half in Q0.32,
      // multiplied together per index bit with rounding, then rounded to Q1.16.
      roots[0] = 64'd1 << 31;
      for (int k = 1; k <= 16; k++) begin
         rad   = roots[k-1] << 32;
         root  = '0;
         probe = 64'd1 << 62;
         while (probe > rad) probe = probe >> 2;
         while (probe != 0) begin
            if (rad >= root + probe) begin
               rad  = rad - (root + probe);
               root = (root >> 1) + probe;
            end else begin
               root = root >> 1;
            end
            probe = probe >> 2;
         end
         roots[k] = root;
      end
      for (int i = 0; i < LUT_DEPTH; i++) begin
         prod = 64'd1 << 32;
         for (int m = 0; m < LUT_BITS; m++) begin
            if (((i >> m) & 1) != 0) prod = (prod * roots[LUT_BITS - m] + (64'd1 << 31)) >> 32;
         end
         prod = (prod + 64'd32768) >> 16;
         pow2_lut[i] = prod[ENTRY_W-1:0];
      end

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed pairs under the reset register values.
      send_idle_pct = 16;
      rcv_idle_pct  = 63;
      @(posedge clock);
      add_pair(16'h0000, 16'h0000, 1'b1);   // zero distance: exactly the gain
      add_pair(16'h7FFF, 16'h8000, 1'b1);   // widest positive difference
      add_pair(16'h8000, 16'h7FFF, 1'b1);   // widest negative difference
      add_pair(16'h8000, 16'h8000, 1'b0);
      add_pair(16'h7FFF, 16'h7FFF, 1'b1);   // two equal coordinates
      add_pair(16'h0100, 16'h0000, 1'b1);   // unit distance
      add_pair(16'h0000, 16'h0001, 1'b1);   // one LSB apart
      add_pair(16'h3039, 16'hEF1F, 1'b0);
      add_pair(16'hFFFF, 16'h0001, 1'b0);
      add_pair(16'h0064, 16'h00C8, 1'b1);
      add_pair(16'h5555, 16'hAAAA, 1'b1);
      add_pair(16'hAAAA, 16'h5555, 1'b1);
      add_pair(16'hFFFF, 16'h8000, 1'b1);
      add_pair(16'h7FFF, 16'h0000, 1'b1);
      add_pair(16'h0080, 16'hFF80, 1'b0);
      add_pair(16'hFF80, 16'h0080, 1'b1);
      add_pair(16'h0200, 16'h0000, 1'b1);
      add_pair(16'h0400, 16'h0000, 1'b1);
      add_pair(16'h0800, 16'h0000, 1'b1);
      wait_drained();

      for (int phase = 0; phase < PHASES; phase++) begin
         // Sender light, receiver heavy; then swapped; then flat out.
         send_idle_pct = (phase < 2) ? 16 : (phase < 4) ? 63 : 0;
         rcv_idle_pct  = (phase < 2) ? 63 : (phase < 4) ? 16 : 0;
         case (phase)
            0: begin gain = '1;                scale = '0;                          end
            1: begin gain = '0;                scale = '1;                          end
            2: begin gain = VAR_W'($urandom);  scale = SCALE_W'($urandom_range(1, 200000)); end
            3: begin gain = '1;                scale = '1;                          end
            4: begin gain = 16'd1;             scale = 24'd1;                       end
            default: begin gain = VAR_W'($urandom); scale = SCALE_W'($urandom);    end
         endcase
         if (phase == 2 || phase == 5) begin
            write_register(CSR_SPARE_A, CSR_DATA_W'($urandom));
            write_register(CSR_SPARE_B, CSR_DATA_W'($urandom));
         end
         // Junk in the upper data bits must not reach the gain.
         write_register(CSR_VARIANCE_GAIN, {8'($urandom), gain});
         write_register(CSR_DISTANCE_SCALE, scale);
         @(posedge clock);

         if (phase == 5) long_stall_req = 1'b1;
         // Drive the sum into saturation, well past the nominal dimension limit.
         if (phase == 0 || phase == 4) begin
            queue_vector($urandom_range(257, 300), STYLE_FLOOD);
            queue_vector($urandom_range(1, 4), STYLE_NEAR);
         end

         mark = pairs_issued;
         while (pairs_issued - mark < RANDOM_PAIRS) begin
            pick = $urandom_range(99);
            if (pick < 60)      len = $urandom_range(1, 6);
            else if (pick < 85) len = $urandom_range(7, 32);
            else if (pick < 95) len = $urandom_range(0, 1) ? 64 : $urandom_range(33, 64);
            else                len = $urandom_range(65, 90);
            pick = $urandom_range(99);
            if (pick < 55)      style = STYLE_NEAR;
            else if (pick < 80) style = STYLE_SPREAD;
            else                style = STYLE_CORNER;
            queue_vector(len, style);
         end
         wait_drained();
      end

      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
